### hw/rtl/dtq_pkg.sv
`default_nettype none
package dtq_pkg;

	// table geometry
	localparam int TIMER_SLOTS = 16;
	localparam int SLOT_BITS   = $clog2(TIMER_SLOTS);
	localparam int TIME_BITS   = 48;
	localparam int ORDER_BITS  = 32;

	// item fields
	localparam int OP_BITS     = 2;
	localparam int DUR_BITS    = 31;
	localparam int HANDLE_BITS = 4;
	localparam int MAXPOP_BITS = 5;
	localparam int OSLOT_BITS  = 4;
	localparam int STATUS_BITS = 2;
	localparam int DELAY_BITS  = 32;

	// at most this many timers leave per pop
	localparam int MAX_POP  = 16;
	localparam int CNT_BITS = $clog2(MAX_POP + 1);

	localparam logic [OP_BITS-1:0] OP_SCHED  = 2'd0;
	localparam logic [OP_BITS-1:0] OP_POP    = 2'd1;
	localparam logic [OP_BITS-1:0] OP_CANCEL = 2'd2;
	localparam logic [OP_BITS-1:0] OP_TICK   = 2'd3;

	localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_MISSING = 2'd2;
	localparam logic [STATUS_BITS-1:0] ST_NONE    = 2'd3;

	localparam logic signed [DELAY_BITS-1:0] DELAY_MAX = {1'b0, {(DELAY_BITS-1){1'b1}}};
	localparam logic signed [DELAY_BITS-1:0] DELAY_MIN = {1'b1, {(DELAY_BITS-1){1'b0}}};

endpackage
`default_nettype wire

### hw/rtl/deadline_timer_queue.sv
`default_nettype none
// Channel   Handshake             Payload
// command   start / busy          op, duration, handle, max_pop
// result    done (strobe)         slot, status, canceled, next_delay, last
//
// An item is taken at an edge with start high and busy low; busy then stays high
// until the last result has been loaded. The slot table is walked by one shared
// compare unit, one slot a cycle, for the earliest timer.
// Results go out on consecutive cycles, one per done strobe; the receiver cannot
// stall. Reset clears time, valid bits and order counter; no clearing pass.
module deadline_timer_queue
	import dtq_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [OP_BITS-1:0]            op,
	input  wire logic [DUR_BITS-1:0]           duration,
	input  wire logic [HANDLE_BITS-1:0]        handle,
	input  wire logic [MAXPOP_BITS-1:0]        max_pop,
	output logic                               done,
	output logic [OSLOT_BITS-1:0]              slot,
	output logic [STATUS_BITS-1:0]             status,
	output logic                               canceled,
	output logic signed [DELAY_BITS-1:0]       next_delay,
	output logic                               last
);

	// sequencer codes
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_CHECK  = 2'd2;
	localparam logic [1:0] S_EMIT   = 2'd3;

	localparam logic [SLOT_BITS-1:0] LAST_IDX = SLOT_BITS'(TIMER_SLOTS - 1);
	localparam logic [TIME_BITS-1:0] TIME_END = '1;

	logic [1:0] state_q;

	// timer table
	logic [TIME_BITS-1:0]  now_q;
	logic [TIMER_SLOTS-1:0] valid_q;
	logic [TIME_BITS-1:0]  dl_mem  [TIMER_SLOTS];
	logic [ORDER_BITS-1:0] ord_mem [TIMER_SLOTS];
	logic [ORDER_BITS-1:0] order_q;

	// scan state: best candidate so far
	logic [SLOT_BITS-1:0]  idx_q;
	logic                  best_valid_q;
	logic [SLOT_BITS-1:0]  best_slot_q;
	logic [TIME_BITS-1:0]  best_dl_q;
	logic [ORDER_BITS-1:0] best_ord_q;

	// pop bookkeeping and pending result
	logic [SLOT_BITS-1:0]      popped_q [MAX_POP];
	logic [CNT_BITS-1:0]       pcount_q;
	logic [CNT_BITS-1:0]       limit_q;
	logic [CNT_BITS-2:0]       eidx_q;
	logic [OSLOT_BITS-1:0]     res_slot_q;
	logic [STATUS_BITS-1:0]    res_status_q;
	logic                      res_canceled_q;
	logic signed [DELAY_BITS-1:0] delay_q;

	// output register
	logic                         done_q;
	logic [OSLOT_BITS-1:0]        slot_q;
	logic [STATUS_BITS-1:0]       status_q;
	logic                         canceled_q;
	logic signed [DELAY_BITS-1:0] next_delay_q;
	logic                         last_q;

	logic accept;
	assign accept = start && (state_q == S_IDLE);

	// lowest free slot
	logic                 have_free;
	logic [SLOT_BITS-1:0] free_slot;
	always_comb begin
		have_free = 1'b0;
		free_slot = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				have_free = 1'b1;
				free_slot = SLOT_BITS'(i);
			end
		end
	end

	// deadline now + duration, held at the end of time
	logic [TIME_BITS:0]   dl_sum;
	logic [TIME_BITS-1:0] new_dl;
	assign dl_sum = {1'b0, now_q} + (TIME_BITS+1)'(duration);
	assign new_dl = dl_sum[TIME_BITS] ? TIME_END : dl_sum[TIME_BITS-1:0];

	logic handle_ok;
	assign handle_ok = (32'(handle) < TIMER_SLOTS) && valid_q[SLOT_BITS'(handle)];

	// shared compare unit: current slot against best so far
	logic [TIME_BITS-1:0]  cand_dl;
	logic [ORDER_BITS-1:0] cand_ord;
	logic [ORDER_BITS-1:0] ord_diff;
	logic                  take;
	assign cand_dl  = dl_mem[idx_q];
	assign cand_ord = ord_mem[idx_q];
	assign ord_diff = cand_ord - best_ord_q;
	// equal deadlines: the later schedule (modular order) wins
	assign take = valid_q[idx_q] && (!best_valid_q || (cand_dl < best_dl_q) ||
		((cand_dl == best_dl_q) && (ord_diff != '0) && !ord_diff[ORDER_BITS-1]));

	// shared subtractor: earliest deadline minus now
	logic [TIME_BITS:0]             diff;
	logic [TIME_BITS-1:DELAY_BITS-1] diff_hi;
	logic                           expired;
	logic signed [DELAY_BITS-1:0]   sat_delay;
	assign diff    = {1'b0, best_dl_q} - {1'b0, now_q};
	assign diff_hi = diff[TIME_BITS-1:DELAY_BITS-1];
	assign expired = diff[TIME_BITS];
	always_comb begin
		if (!best_valid_q)
			sat_delay = DELAY_MAX;
		else if (!diff[TIME_BITS] && (|diff_hi))
			sat_delay = DELAY_MAX;
		else if (diff[TIME_BITS] && !(&diff_hi))
			sat_delay = DELAY_MIN;
		else
			sat_delay = diff[DELAY_BITS-1:0];
	end

	logic popping;
	assign popping = (pcount_q < limit_q) && best_valid_q && expired;

	logic emit_last;
	assign emit_last = (pcount_q == '0) || ((CNT_BITS'(eidx_q) + 1'b1) == pcount_q);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			now_q        <= '0;
			valid_q      <= '0;
			order_q      <= '0;
			idx_q        <= '0;
			best_valid_q <= 1'b0;
			pcount_q     <= '0;
			limit_q      <= '0;
			eidx_q       <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q      <= S_SCAN;
						idx_q        <= '0;
						best_valid_q <= 1'b0;
						pcount_q     <= '0;
						eidx_q       <= '0;
						limit_q      <= '0;
						case (op)
							OP_SCHED: begin
								if (have_free) begin
									valid_q[free_slot] <= 1'b1;
									order_q            <= order_q + 1'b1;
								end
							end
							OP_POP: begin
								limit_q <= (32'(max_pop) > MAX_POP) ? CNT_BITS'(MAX_POP)
								                                    : CNT_BITS'(max_pop);
							end
							OP_CANCEL: begin
								if (handle_ok)
									valid_q[SLOT_BITS'(handle)] <= 1'b0;
							end
							default: begin
								if (now_q != TIME_END)
									now_q <= now_q + 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (take)
						best_valid_q <= 1'b1;
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= S_CHECK;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_CHECK: begin
					if (popping) begin
						valid_q[best_slot_q] <= 1'b0;
						pcount_q             <= pcount_q + 1'b1;
						best_valid_q         <= 1'b0;
						state_q              <= S_SCAN;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					done_q <= 1'b1;
					eidx_q <= eidx_q + 1'b1;
					if (emit_last)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_slot_q     <= '0;
			res_status_q   <= ST_OK;
			res_canceled_q <= 1'b0;
			case (op)
				OP_SCHED: begin
					if (have_free) begin
						dl_mem[free_slot]  <= new_dl;
						ord_mem[free_slot] <= order_q;
						res_slot_q         <= OSLOT_BITS'(free_slot);
					end else begin
						res_status_q <= ST_FULL;
					end
				end
				OP_POP:    res_status_q <= ST_NONE;
				OP_CANCEL: begin
					res_slot_q     <= handle;
					res_status_q   <= handle_ok ? ST_OK : ST_MISSING;
					res_canceled_q <= handle_ok;
				end
				default: ;
			endcase
		end
		if ((state_q == S_SCAN) && take) begin
			best_slot_q <= idx_q;
			best_dl_q   <= cand_dl;
			best_ord_q  <= cand_ord;
		end
		if (state_q == S_CHECK) begin
			if (popping)
				popped_q[pcount_q[CNT_BITS-2:0]] <= best_slot_q;
			else
				delay_q <= sat_delay;
		end
		if (state_q == S_EMIT) begin
			next_delay_q <= delay_q;
			last_q       <= emit_last;
			canceled_q   <= res_canceled_q;
			if (pcount_q != '0) begin
				slot_q   <= OSLOT_BITS'(popped_q[eidx_q]);
				status_q <= ST_OK;
			end else begin
				slot_q   <= res_slot_q;
				status_q <= res_status_q;
			end
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign slot       = slot_q;
	assign status     = status_q;
	assign canceled   = canceled_q;
	assign next_delay = next_delay_q;
	assign last       = last_q;

	// results of one pop leave back to back
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> done)
		else $error("result burst broken before last");

	// an accepted item holds the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	// a failed or empty outcome is always a single result
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_OK) |-> last && !canceled)
		else $error("error result not single");

	// pop count never passes its limit
	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		pcount_q <= limit_q)
		else $error("pop count beyond limit");

endmodule
`default_nettype wire
